/* design/tcq_pkg.sv */
// Shared types and constants for the two-class transmit queue.
`default_nettype none

package tcq_pkg;

  localparam int RING_DEPTH = 64;
  localparam int RING_AW    = $clog2(RING_DEPTH);
  localparam int RING_CW    = $clog2(RING_DEPTH + 1);
  localparam int SLOT_COUNT = 16;
  localparam int SLOT_AW    = $clog2(SLOT_COUNT);
  localparam int PCNT_W     = $clog2(SLOT_COUNT + 1);
  localparam int TAG_W      = 16;
  localparam int MSG_W      = 4;
  localparam int DEPTH_W    = 7;
  localparam int ENTRY_W    = MSG_W + TAG_W;

  typedef logic [RING_AW-1:0] ring_ptr_t;
  typedef logic [RING_CW-1:0] ring_cnt_t;
  typedef logic [SLOT_AW-1:0] slot_idx_t;
  typedef logic [PCNT_W-1:0]  pcnt_t;
  typedef logic [DEPTH_W-1:0] depth_t;
  typedef logic [TAG_W-1:0]   tag_t;
  typedef logic [MSG_W-1:0]   msg_t;
  typedef logic [ENTRY_W-1:0] entry_t;

  typedef enum logic [1:0] {
    CMD_ENQ = 2'd0,
    CMD_DEQ = 2'd1,
    CMD_REQ = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    ST_ENQUEUED  = 3'd0,
    ST_COALESCED = 3'd1,
    ST_DROPPED   = 3'd2,
    ST_DEQUEUED  = 3'd3,
    ST_EMPTY     = 3'd4,
    ST_REJECTED  = 3'd5
  } status_t;

  typedef struct packed {
    cmd_t cmd;
    logic keep_newest;
    msg_t msg_slot;
    tag_t packet_tag;
  } item_t;

  typedef struct packed {
    status_t status;
    tag_t    tag;
    msg_t    slot;
    logic    keep_newest;
    depth_t  depth;
    logic    from_ring;   // tag and slot come from the ring read port
  } result_t;

  typedef struct packed {
    logic      wr_en;
    ring_ptr_t wr_addr;
    entry_t    wr_data;
    logic      rd_en;
    ring_ptr_t rd_addr;
  } ring_req_t;

endpackage

`default_nettype wire

/* design/two_class_tx_queue.sv */
// Top level: input register, queue control, ring memory and result register.
//
//  channel | dir | tdata (low bit up)                    | tuser (low bit up)
//  in_     | in  | msg_slot[3:0], packet_tag[19:4]       | cmd[1:0], keep_newest[2]
//  out_    | out | out_tag[15:0], out_slot[19:16],       | status[2:0],
//          |     | depth[26:20]                          | out_keep_newest[3]
//
// One item per cycle while the output does not stall; each item passes the input
// register, then the result register, which holds its result.
// The ring memory read register loads at the same edge as the result register.
// Reset clears ring pointers and pending bits; stores need no clearing pass.
// A stalled output holds the result; the input register keeps taking items
// as long as the result register drains.
`default_nettype none

module two_class_tx_queue (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // msg_slot[3:0], packet_tag[19:4], zero pad
  input  wire logic [2:0]  in_tuser,   // cmd[1:0], keep_newest[2]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // out_tag[15:0], out_slot[19:16], depth[26:20], pad
  output logic [3:0]       out_tuser   // status[2:0], out_keep_newest[3]
);

  logic               s1_valid_r;
  tcq_pkg::item_t     s1_item_r;
  tcq_pkg::item_t     in_item;
  logic               out_valid_r;
  tcq_pkg::result_t   res_r;
  tcq_pkg::result_t   res;
  tcq_pkg::ring_req_t ring_req;
  tcq_pkg::entry_t    rd_data;
  logic               advance;
  tcq_pkg::tag_t      tag;
  tcq_pkg::msg_t      slot;

  assign in_item.cmd         = tcq_pkg::cmd_t'(in_tuser[1:0]);
  assign in_item.keep_newest = in_tuser[2];
  assign in_item.msg_slot    = in_tdata[3:0];
  assign in_item.packet_tag  = in_tdata[19:4];

  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_item_r <= in_item;
    end
    if (advance) begin
      res_r <= res;
    end
  end

  tcq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire     (advance),
    .item     (s1_item_r),
    .ring_req (ring_req),
    .result   (res)
  );

  tcq_ring_mem u_ring (
    .clk     (clk),
    .req     (ring_req),
    .rd_data (rd_data)
  );

  // ring dequeues take tag and slot from the memory's read register
  assign tag  = res_r.from_ring ? rd_data[tcq_pkg::TAG_W-1:0] : res_r.tag;
  assign slot = res_r.from_ring ? rd_data[tcq_pkg::ENTRY_W-1:tcq_pkg::TAG_W] : res_r.slot;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, res_r.depth, slot, tag};
  assign out_tuser  = {res_r.keep_newest, res_r.status};

endmodule

`default_nettype wire

/* design/tcq_ring_mem.sv */
// Ring descriptor storage: one write port, one registered read port.
`default_nettype none

module tcq_ring_mem (
  input  wire logic               clk,
  input  wire tcq_pkg::ring_req_t req,
  output tcq_pkg::entry_t         rd_data
);

  tcq_pkg::entry_t mem [tcq_pkg::RING_DEPTH];
  tcq_pkg::entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

/* design/tcq_ctrl.sv */
// Queue state: ring pointers, latest-only slots and per-item decision.
`default_nettype none

module tcq_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               fire,
  input  wire tcq_pkg::item_t     item,
  output tcq_pkg::ring_req_t      ring_req,
  output tcq_pkg::result_t        result
);

  tcq_pkg::ring_ptr_t head_r, head_nxt;
  tcq_pkg::ring_cnt_t cnt_r, cnt_nxt;
  logic [tcq_pkg::SLOT_COUNT-1:0] pend_r, pend_nxt;
  tcq_pkg::pcnt_t     pcnt_r, pcnt_nxt;
  tcq_pkg::tag_t      slot_tag_r [tcq_pkg::SLOT_COUNT];

  tcq_pkg::slot_idx_t idx;
  tcq_pkg::slot_idx_t pick;
  logic [tcq_pkg::SLOT_COUNT-1:0] lowbit;
  logic               full;
  logic               slot_we;
  tcq_pkg::ring_req_t req;
  tcq_pkg::result_t   res;

  assign idx  = tcq_pkg::slot_idx_t'(item.msg_slot);
  assign full = (cnt_r == tcq_pkg::ring_cnt_t'(tcq_pkg::RING_DEPTH));

  // lowest pending slot
  assign lowbit = pend_r & (~pend_r + 1'b1);
  always_comb begin
    pick = '0;
    for (int i = 0; i < tcq_pkg::SLOT_COUNT; i++) begin
      if (lowbit[i]) begin
        pick = pick | tcq_pkg::slot_idx_t'(i);
      end
    end
  end

  always_comb begin
    head_nxt        = head_r;
    cnt_nxt         = cnt_r;
    pend_nxt        = pend_r;
    pcnt_nxt        = pcnt_r;
    slot_we         = 1'b0;
    req             = '0;
    res             = '0;
    res.status      = tcq_pkg::ST_EMPTY;
    unique case (item.cmd)
      tcq_pkg::CMD_ENQ: begin
        if (item.keep_newest) begin
          res.status    = pend_r[idx] ? tcq_pkg::ST_COALESCED : tcq_pkg::ST_ENQUEUED;
          slot_we       = 1'b1;
          pend_nxt[idx] = 1'b1;
          if (!pend_r[idx]) begin
            pcnt_nxt = pcnt_r + 1'b1;
          end
        end else if (full) begin
          res.status = tcq_pkg::ST_DROPPED;
        end else begin
          req.wr_en   = 1'b1;
          req.wr_addr = tcq_pkg::ring_ptr_t'(head_r + tcq_pkg::ring_ptr_t'(cnt_r));
          req.wr_data = {item.msg_slot, item.packet_tag};
          cnt_nxt     = cnt_r + 1'b1;
          res.status  = tcq_pkg::ST_ENQUEUED;
        end
      end
      tcq_pkg::CMD_DEQ: begin
        if (cnt_r != '0) begin
          req.rd_en     = 1'b1;
          req.rd_addr   = head_r;
          head_nxt      = head_r + 1'b1;
          cnt_nxt       = cnt_r - 1'b1;
          res.from_ring = 1'b1;
          res.status    = tcq_pkg::ST_DEQUEUED;
        end else if (pend_r != '0) begin
          pend_nxt[pick]  = 1'b0;
          pcnt_nxt        = pcnt_r - 1'b1;
          res.tag         = slot_tag_r[pick];
          res.slot        = tcq_pkg::msg_t'(pick);
          res.keep_newest = 1'b1;
          res.status      = tcq_pkg::ST_DEQUEUED;
        end
      end
      tcq_pkg::CMD_REQ: begin
        if (full) begin
          res.status = tcq_pkg::ST_REJECTED;
        end else begin
          head_nxt    = head_r - 1'b1;
          req.wr_en   = 1'b1;
          req.wr_addr = head_nxt;
          req.wr_data = {item.msg_slot, item.packet_tag};
          cnt_nxt     = cnt_r + 1'b1;
          res.status  = tcq_pkg::ST_ENQUEUED;
        end
      end
      default: begin
        // unused code: report empty, leave state alone
      end
    endcase
    res.depth = tcq_pkg::depth_t'(cnt_nxt) + tcq_pkg::depth_t'(pcnt_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      cnt_r  <= '0;
      pend_r <= '0;
      pcnt_r <= '0;
    end else if (fire) begin
      head_r <= head_nxt;
      cnt_r  <= cnt_nxt;
      pend_r <= pend_nxt;
      pcnt_r <= pcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && slot_we) begin
      slot_tag_r[idx] <= item.packet_tag;
    end
  end

  always_comb begin
    ring_req       = req;
    ring_req.wr_en = req.wr_en & fire;
    ring_req.rd_en = req.rd_en & fire;
  end

  assign result = res;

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= tcq_pkg::ring_cnt_t'(tcq_pkg::RING_DEPTH))
    else $error("ring count past depth");

  a_pcnt_match: assert property (@(posedge clk) disable iff (!rst_n)
    pcnt_r == tcq_pkg::pcnt_t'($countones(pend_r)))
    else $error("pending count out of step with pending bits");

  a_one_port: assert property (@(posedge clk) disable iff (!rst_n)
    !(ring_req.wr_en && ring_req.rd_en))
    else $error("ring read and write in one item");

  a_ring_first: assert property (@(posedge clk) disable iff (!rst_n)
    ring_req.rd_en |=> pend_r == $past(pend_r))
    else $error("slot served while ring held items");
`endif

endmodule

`default_nettype wire

/* bench/tcq_checker.sv */
// Watches both channels of the transmit queue, predicts each reply and compares it.
module tcq_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [23:0] in_tdata,   // msg_slot[3:0], packet_tag[19:4], pad
  input  wire logic [2:0]  in_tuser,   // cmd[1:0], keep_newest[2]
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [31:0] out_tdata,  // out_tag[15:0], out_slot[19:16], depth[26:20], pad
  input  wire logic [3:0]  out_tuser,  // status[2:0], out_keep_newest[3]
  output logic [31:0]      fail_count,
  output logic [31:0]      replies_waiting,
  output logic [31:0]      replies_checked,
  output logic [31:0]      full_hits,
  output logic [31:0]      coalesce_hits
);

  typedef struct packed {
    tcq_pkg::status_t status;
    tcq_pkg::tag_t    tag;
    tcq_pkg::msg_t    slot;
    logic             keep_newest;
    tcq_pkg::depth_t  depth;
  } tx_reply_t;

  // shadow copy of the queue
  tcq_pkg::entry_t                ring_mem [tcq_pkg::RING_DEPTH];
  tcq_pkg::ring_ptr_t             ring_front = '0;
  int                             ring_fill = 0;
  tcq_pkg::tag_t                  slot_tag [tcq_pkg::SLOT_COUNT];
  logic [tcq_pkg::SLOT_COUNT-1:0] slot_busy = '0;

  tx_reply_t predicted_replies [$];
  int        n_fail = 0;
  int        n_checked = 0;
  int        n_full = 0;
  int        n_coalesce = 0;

  initial begin
    fail_count      = '0;
    replies_waiting = '0;
    replies_checked = '0;
    full_hits       = '0;
    coalesce_hits   = '0;
  end

  function automatic tx_reply_t apply_queue_cmd(logic [1:0] cmd, logic lo,
                                                tcq_pkg::msg_t slot, tcq_pkg::tag_t tag);
    tx_reply_t          r;
    tcq_pkg::slot_idx_t idx;
    tcq_pkg::ring_ptr_t wr;
    tcq_pkg::entry_t    e;
    logic               found;
    int                 n;
    r.status      = tcq_pkg::ST_EMPTY;
    r.tag         = '0;
    r.slot        = '0;
    r.keep_newest = 1'b0;
    if (cmd == tcq_pkg::CMD_ENQ) begin
      if (lo) begin
        idx = tcq_pkg::slot_idx_t'(int'(slot) % tcq_pkg::SLOT_COUNT);
        r.status = slot_busy[idx] ? tcq_pkg::ST_COALESCED : tcq_pkg::ST_ENQUEUED;
        slot_tag[idx]  = tag;
        slot_busy[idx] = 1'b1;
      end else if (ring_fill >= tcq_pkg::RING_DEPTH) begin
        r.status = tcq_pkg::ST_DROPPED;
      end else begin
        wr = tcq_pkg::ring_ptr_t'((int'(ring_front) + ring_fill) % tcq_pkg::RING_DEPTH);
        ring_mem[wr] = {slot, tag};
        ring_fill++;
        r.status = tcq_pkg::ST_ENQUEUED;
      end
    end else if (cmd == tcq_pkg::CMD_DEQ) begin
      if (ring_fill != 0) begin
        e = ring_mem[ring_front];
        ring_front = tcq_pkg::ring_ptr_t'((int'(ring_front) + 1) % tcq_pkg::RING_DEPTH);
        ring_fill--;
        r.tag    = e[tcq_pkg::TAG_W-1:0];
        r.slot   = e[tcq_pkg::ENTRY_W-1:tcq_pkg::TAG_W];
        r.status = tcq_pkg::ST_DEQUEUED;
      end else begin
        // ring empty: lowest pending slot wins
        found = 1'b0;
        for (int i = 0; i < tcq_pkg::SLOT_COUNT; i++) begin
          if (!found && slot_busy[i]) begin
            found         = 1'b1;
            slot_busy[i]  = 1'b0;
            r.tag         = slot_tag[i];
            r.slot        = tcq_pkg::msg_t'(i);
            r.keep_newest = 1'b1;
            r.status      = tcq_pkg::ST_DEQUEUED;
          end
        end
      end
    end else if (cmd == tcq_pkg::CMD_REQ) begin
      // keep-newest flag is ignored here; the item goes to the ring front unless the ring is full
      if (ring_fill >= tcq_pkg::RING_DEPTH) begin
        r.status = tcq_pkg::ST_REJECTED;
      end else begin
        ring_front = tcq_pkg::ring_ptr_t'((int'(ring_front) + tcq_pkg::RING_DEPTH - 1)
                                          % tcq_pkg::RING_DEPTH);
        ring_mem[ring_front] = {slot, tag};
        ring_fill++;
        r.status = tcq_pkg::ST_ENQUEUED;
      end
    end
    n = ring_fill;
    for (int i = 0; i < tcq_pkg::SLOT_COUNT; i++) n += int'(slot_busy[i]);
    r.depth = tcq_pkg::depth_t'(n);
    return r;
  endfunction

  always @(posedge clk) begin
    tx_reply_t exp_r;
    tx_reply_t act_r;
    if (!rst_n) begin
      ring_front = '0;
      ring_fill  = 0;
      slot_busy  = '0;
      predicted_replies.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        act_r.status      = tcq_pkg::status_t'(out_tuser[2:0]);
        act_r.keep_newest = out_tuser[3];
        act_r.tag         = out_tdata[15:0];
        act_r.slot        = out_tdata[19:16];
        act_r.depth       = out_tdata[26:20];
        if (predicted_replies.size() == 0) begin
          n_fail++;
          if (n_fail <= 10)
            $display("MISMATCH: reply with no item waiting: status %0d tag %h slot %0d %s",
                     out_tuser[2:0], act_r.tag, act_r.slot,
                     $sformatf("lo %0d depth %0d", act_r.keep_newest, act_r.depth));
        end else begin
          exp_r = predicted_replies.pop_front();
          n_checked++;
          if (exp_r.status == tcq_pkg::ST_DROPPED || exp_r.status == tcq_pkg::ST_REJECTED)
            n_full++;
          if (exp_r.status == tcq_pkg::ST_COALESCED) n_coalesce++;
          if (exp_r.status != out_tuser[2:0] || exp_r.tag != act_r.tag ||
              exp_r.slot != act_r.slot || exp_r.keep_newest != act_r.keep_newest ||
              exp_r.depth != act_r.depth) begin
            n_fail++;
            if (n_fail <= 10) begin
              $display("MISMATCH reply %0d: exp status %0d tag %h slot %0d lo %0d depth %0d",
                       n_checked, exp_r.status, exp_r.tag, exp_r.slot, exp_r.keep_newest,
                       exp_r.depth);
              $display("  got status %0d tag %h slot %0d lo %0d depth %0d",
                       out_tuser[2:0], act_r.tag, act_r.slot, act_r.keep_newest,
                       act_r.depth);
            end
          end
        end
      end
      if (in_tvalid && in_tready)
        predicted_replies.push_back(apply_queue_cmd(in_tuser[1:0], in_tuser[2],
                                                    in_tdata[3:0], in_tdata[19:4]));
    end
    fail_count      <= n_fail;
    replies_waiting <= predicted_replies.size();
    replies_checked <= n_checked;
    full_hits       <= n_full;
    coalesce_hits   <= n_coalesce;
  end

endmodule

/* bench/two_class_tx_queue_tb.sv */
// Stimulus, flow control and verdict for the two-class transmit queue.
module two_class_tx_queue_tb;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;   // msg_slot[3:0], packet_tag[19:4], pad
  logic [2:0]  in_tuser;   // cmd[1:0], keep_newest[2]
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;  // out_tag[15:0], out_slot[19:16], depth[26:20], pad
  logic [3:0]  out_tuser;  // status[2:0], out_keep_newest[3]

  logic [31:0] fail_count;
  logic [31:0] replies_waiting;
  logic [31:0] replies_checked;
  logic [31:0] full_hits;
  logic [31:0] coalesce_hits;

  localparam int RANDOM_ITEMS = 1600;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  int  items_sent = 0;
  bit  no_gaps = 1'b0;

  two_class_tx_queue u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  tcq_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tuser      (out_tuser),
    .fail_count     (fail_count),
    .replies_waiting(replies_waiting),
    .replies_checked(replies_checked),
    .full_hits      (full_hits),
    .coalesce_hits  (coalesce_hits)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #8000000;
    $display("timeout: %0d replies still waiting", replies_waiting);
    $display("two_class_tx_queue regression: fail");
    $finish;
  end

  // result side back-pressure: calm stretches and stretches with stalls
  initial begin
    int stall_left;
    int stretch_left;
    bit stalls_on;
    stall_left   = 0;
    stretch_left = 0;
    stalls_on    = 1'b0;
    out_tready   = 1'b0;
    forever begin
      @(posedge clk);
      if (stretch_left == 0) begin
        stretch_left = $urandom_range(200, 20);
        stalls_on    = ($urandom_range(3) != 0);
      end
      stretch_left--;
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (stalls_on && $urandom_range(99) < 25) begin
        stall_left = ($urandom_range(99) < 90) ? $urandom_range(2, 0) : $urandom_range(60, 15);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // called at a rising edge; returns at the edge where the item is taken
  task automatic send_item(logic [1:0] cmd, logic lo, tcq_pkg::msg_t slot,
                           tcq_pkg::tag_t tag);
    int gap;
    int r;
    gap = 0;
    if (!no_gaps) begin
      r = $urandom_range(99);
      if (r >= 92)      gap = $urandom_range(40, 8);
      else if (r >= 55) gap = $urandom_range(3, 1);
    end
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      in_tdata  <= 24'($urandom());
      in_tuser  <= 3'($urandom());
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'h0, tag, slot};
    in_tuser  <= {lo, cmd};
    @(negedge clk);
    while (!in_tready) begin
      @(posedge clk);
      @(negedge clk);
    end
    @(posedge clk);
    items_sent++;
  endtask

  initial begin
    int   phase_kind;
    int   phase_len;
    int   r;
    bit   hot_slots;
    logic [1:0] cmd;
    logic lo;
    tcq_pkg::msg_t slot;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty queue, unused code, both classes, priority order
    send_item(tcq_pkg::CMD_DEQ, 1'b0, 4'd0, 16'h0000);
    send_item(CMD_UNUSED, 1'b0, 4'd0, 16'h0000);
    send_item(tcq_pkg::CMD_REQ, 1'b1, 4'd5, 16'h1234);   // keep-newest ignored on requeue
    send_item(tcq_pkg::CMD_ENQ, 1'b1, 4'd0, 16'hFFFF);
    send_item(tcq_pkg::CMD_ENQ, 1'b1, 4'd0, 16'h0000);   // same slot again: coalesced
    send_item(tcq_pkg::CMD_ENQ, 1'b1, 4'd15, 16'hA5A5);
    send_item(tcq_pkg::CMD_ENQ, 1'b0, 4'd15, 16'hFFFF);
    send_item(tcq_pkg::CMD_ENQ, 1'b0, 4'd0, 16'h0000);
    send_item(tcq_pkg::CMD_REQ, 1'b0, 4'd9, 16'h5A5A);
    send_item(CMD_UNUSED, 1'b1, 4'd15, 16'hFFFF);        // unused code with live state
    repeat (4) send_item(tcq_pkg::CMD_DEQ, 1'b1, 4'd15, 16'hFFFF);
    send_item(tcq_pkg::CMD_DEQ, 1'b0, 4'd0, 16'h0000);   // slots now: 0 first
    send_item(tcq_pkg::CMD_DEQ, 1'b0, 4'd0, 16'h0000);
    send_item(tcq_pkg::CMD_DEQ, 1'b0, 4'd0, 16'h0000);   // empty again
    send_item(tcq_pkg::CMD_ENQ, 1'b1, 4'd7, 16'h00FF);
    send_item(tcq_pkg::CMD_ENQ, 1'b1, 4'd3, 16'hFF00);
    send_item(tcq_pkg::CMD_ENQ, 1'b0, 4'd12, 16'h8001);
    repeat (3) send_item(tcq_pkg::CMD_DEQ, 1'b0, 4'd0, 16'h0000);

    // random phases: filling to the ring limit, draining, and a mix
    while (items_sent < RANDOM_ITEMS + 22) begin
      phase_kind = $urandom_range(2);
      phase_len  = $urandom_range(160, 40);
      no_gaps    = ($urandom_range(3) == 0);
      hot_slots  = $urandom_range(1);
      repeat (phase_len) begin
        r    = $urandom_range(99);
        lo   = $urandom_range(1);
        slot = hot_slots ? tcq_pkg::msg_t'($urandom_range(3))
                         : tcq_pkg::msg_t'($urandom_range(15));
        case (phase_kind)
          0: begin
            if (r < 60)      begin cmd = tcq_pkg::CMD_ENQ; lo = 1'b0; end
            else if (r < 75) cmd = tcq_pkg::CMD_REQ;
            else if (r < 90) begin cmd = tcq_pkg::CMD_ENQ; lo = 1'b1; end
            else             cmd = tcq_pkg::CMD_DEQ;
          end
          1: begin
            if (r < 75)      cmd = tcq_pkg::CMD_DEQ;
            else if (r < 85) begin cmd = tcq_pkg::CMD_ENQ; lo = 1'b0; end
            else if (r < 95) begin cmd = tcq_pkg::CMD_ENQ; lo = 1'b1; end
            else             cmd = tcq_pkg::CMD_REQ;
          end
          default: begin
            if (r < 30)      begin cmd = tcq_pkg::CMD_ENQ; lo = 1'b0; end
            else if (r < 50) begin cmd = tcq_pkg::CMD_ENQ; lo = 1'b1; end
            else if (r < 80) cmd = tcq_pkg::CMD_DEQ;
            else if (r < 95) cmd = tcq_pkg::CMD_REQ;
            else             cmd = CMD_UNUSED;
          end
        endcase
        send_item(cmd, lo, slot, tcq_pkg::tag_t'($urandom_range(16'hFFFF)));
      end
    end

    in_tvalid <= 1'b0;
    // let the checker's count take in the last accepted item
    @(posedge clk);
    while (replies_waiting != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("sent %0d items; checked %0d replies, %0d hit a full ring, %0d coalesced",
             items_sent, replies_checked, full_hits, coalesce_hits);
    if (fail_count == 0) begin
      $display("two_class_tx_queue regression: pass");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("two_class_tx_queue regression: fail");
    end
    $finish;
  end

endmodule
